FILE: hdl/argsort_pkg.sv
`default_nettype none

package argsort_pkg;

    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_req;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]           position;
        logic signed [SAMPLE_W-1:0] sorted_value;
        logic                       end_of_run;
        logic                       overflow;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic drop;
        logic shift;
        logic finish;
    } argsort_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic last;
    } argsort_stat_t;

endpackage

`default_nettype wire

FILE: hdl/argsort_ctrl.sv
`default_nettype none

module argsort_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_final_req,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    input  wire argsort_pkg::argsort_stat_t stat,
    output argsort_pkg::argsort_cmd_t     cmd
);
    import argsort_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   out_xfer;

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = (state_reg == ST_EMIT);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    assign cmd.insert = in_xfer && !stat.full;
    assign cmd.drop   = in_xfer && stat.full;
    assign cmd.shift  = out_xfer;
    assign cmd.finish = out_xfer && stat.last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer && s_final_req) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer && stat.last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/argsort_dp.sv
`default_nettype none

module argsort_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire argsort_pkg::in_item_t     in_item,
    input  wire argsort_pkg::argsort_cmd_t cmd,
    output argsort_pkg::argsort_stat_t     stat,
    output argsort_pkg::out_item_t         out_item
);
    import argsort_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // The cell row is kept sorted in descending order at all times. Cells at
    // or beyond the fill count hold nothing of interest.
    logic signed [SAMPLE_W-1:0] val_reg  [MAX_ITEMS];
    logic signed [SAMPLE_W-1:0] val_next [MAX_ITEMS];
    logic [POS_W-1:0]           pos_reg  [MAX_ITEMS];
    logic [POS_W-1:0]           pos_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]       lt;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       dropped_reg;
    logic                       dropped_next;
    logic [POS_W-1:0]           new_pos;

    assign new_pos = POS_W'(count_reg);

    // A cell is overtaken by the new value when it is empty or strictly
    // smaller. Equal values stay ahead, since they arrived earlier.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            lt[i] = (CNT_W'(i) >= count_reg) || (val_reg[i] < in_item.sample);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            val_next[i] = val_reg[i];
            pos_next[i] = pos_reg[i];
        end
        if (cmd.insert) begin
            if (lt[0]) begin
                val_next[0] = in_item.sample;
                pos_next[0] = new_pos;
            end
            for (int i = 1; i < MAX_ITEMS; i++) begin
                if (lt[i]) begin
                    if (lt[i-1]) begin
                        val_next[i] = val_reg[i-1];
                        pos_next[i] = pos_reg[i-1];
                    end else begin
                        val_next[i] = in_item.sample;
                        pos_next[i] = new_pos;
                    end
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                val_next[i] = val_reg[i+1];
                pos_next[i] = pos_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.shift) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.drop) begin
            dropped_next = 1'b1;
        end else if (cmd.finish) begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            val_reg[i] <= val_next[i];
            pos_reg[i] <= pos_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign stat.full = (count_reg == CNT_W'(MAX_ITEMS));
    assign stat.last = (count_reg == CNT_W'(1));

    assign out_item.position     = pos_reg[0];
    assign out_item.sorted_value = val_reg[0];
    assign out_item.end_of_run   = stat.last;
    assign out_item.overflow     = dropped_reg;

endmodule

`default_nettype wire

FILE: hdl/argsort_descending.sv
`default_nettype none

// Channel   Ports                        Contents
// input     s_valid, s_ready, s_data     sample, final_req
// result    m_valid, m_ready, m_data     position, sorted_value, end_of_run, overflow
//
// Each input transfer inserts its value into a sorted row of cells, or drops it and sets the overflow flag when full.
// After the final item, the set of N values leaves one per cycle from the head
// of the row, as long as the output is not stalled.
// The input is not ready while a set is being emitted; output stalls just hold.
// Reset clears the fill count, the overflow flag and the controller state only.

module argsort_descending #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire argsort_pkg::in_item_t s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output argsort_pkg::out_item_t     m_data
);
    import argsort_pkg::*;

    argsort_cmd_t  cmd;
    argsort_stat_t stat;

    argsort_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_final_req (s_data.final_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    argsort_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (m_data)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;

    import argsort_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 76;
    localparam int DRILL_ROWS   = 20;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 20;

    // One row of the directed part: the sample is sent reps times, and final_req
    // (if set) goes out on the last copy only.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_req;
        logic [6:0]                 reps;
        logic                       pinned;
        out_item_t                  pin;
    } drill_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Predictor state: the open set in arrival order.
    logic signed [SAMPLE_W-1:0] set_values [CAPACITY];
    int        set_count = 0;
    bit        set_lost  = 1'b0;
    out_item_t awaited_ranks [$];

    int        mismatches    = 0;
    int        samples_sent  = 0;
    int        sets_closed   = 0;
    int        overflow_sets = 0;
    int        results_seen  = 0;
    int        ready_hold    = 0;
    int        idle_cycles   = 0;
    bit        steady        = 1'b0;
    out_item_t want;

    drill_row_t drill_plan [DRILL_ROWS] = '{
        '{32'h7FFFFFFF, 1'b1, 7'd1,  1'b1, '{6'd0, 32'h7FFFFFFF, 1'b1, 1'b0}},
        '{32'h80000000, 1'b1, 7'd1,  1'b1, '{6'd0, 32'h80000000, 1'b1, 1'b0}},
        '{32'h00000000, 1'b1, 7'd1,  1'b1, '{6'd0, 32'h00000000, 1'b1, 1'b0}},
        '{32'h80000000, 1'b0, 7'd1,  1'b0, '0},
        '{32'h7FFFFFFF, 1'b0, 7'd1,  1'b0, '0},
        '{32'hFFFFFFFF, 1'b0, 7'd1,  1'b0, '0},
        '{32'h00000001, 1'b0, 7'd1,  1'b0, '0},
        '{32'hFFFF0000, 1'b0, 7'd1,  1'b0, '0},
        '{32'h00010000, 1'b1, 7'd1,  1'b0, '0},
        '{32'h00050000, 1'b0, 7'd2,  1'b0, '0},
        '{32'hFFFD0000, 1'b0, 7'd1,  1'b0, '0},
        '{32'h00050000, 1'b0, 7'd1,  1'b0, '0},
        '{32'hFFFD0000, 1'b1, 7'd1,  1'b0, '0},
        '{32'h00000003, 1'b0, 7'd1,  1'b0, '0},
        '{32'h00000002, 1'b0, 7'd1,  1'b0, '0},
        '{32'h00000001, 1'b1, 7'd1,  1'b0, '0},
        '{32'h55555555, 1'b0, 7'd63, 1'b0, '0},
        '{32'hAAAAAAAA, 1'b0, 7'd1,  1'b0, '0},
        '{32'h12345678, 1'b1, 7'd1,  1'b0, '0},
        '{32'h0000ABCD, 1'b1, 7'd1,  1'b1, '{6'd0, 32'h0000ABCD, 1'b1, 1'b0}}
    };

    argsort_descending #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return $urandom_range(1, 2);
        end else if (pick < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return $urandom;
        end else if (pick < 75) begin
            // Narrow range so that equal values show up often.
            return int'($urandom_range(0, 6)) - 3;
        end else if (pick < 85) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFFFFFF;
                1:       return 32'h80000000;
                2:       return 32'hFFFFFFFF;
                default: return 32'h00000000;
            endcase
        end
        return (int'($urandom_range(0, 200)) - 100) <<< 16;
    endfunction

    // Stores the sample into the open set if it has room; a final sample closes
    // the set and queues its values in descending order, equal values by arrival.
    task automatic take_sample(input in_item_t it);
        int        order [CAPACITY];
        int        i;
        int        j;
        out_item_t r;
        if (set_count < CAPACITY) begin
            set_values[set_count] = it.sample;
            set_count++;
        end else begin
            set_lost = 1'b1;
        end
        if (it.final_req) begin
            for (i = 0; i < set_count; i++) begin
                j = i;
                while (j > 0 && set_values[order[j-1]] < set_values[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (i = 0; i < set_count; i++) begin
                r.position     = POS_W'(order[i]);
                r.sorted_value = set_values[order[i]];
                r.end_of_run   = (i == set_count - 1);
                r.overflow     = set_lost;
                awaited_ranks = {awaited_ranks, r};
            end
            sets_closed++;
            if (set_lost) begin
                overflow_sets++;
            end
            set_count = 0;
            set_lost  = 1'b0;
        end
    endtask

    task automatic push_sample(input in_item_t it);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        take_sample(it);
        samples_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_ranks.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, no new ones started while the steady flag is up.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
                ready_hold <= idle_span();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_ranks.size() == 0) begin
                $error("unexpected result transfer: position %0d, sorted_value %0d",
                       m_data.position, m_data.sorted_value);
                mismatches++;
            end else begin
                want = awaited_ranks.pop_front();
                if (m_data.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, m_data.position);
                    mismatches++;
                end
                if (m_data.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, m_data.sorted_value);
                    mismatches++;
                end
                if (m_data.end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b",
                           want.end_of_run, m_data.end_of_run);
                    mismatches++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_data.overflow);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, awaited_ranks.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        in_item_t item;
        int       row;
        int       k;
        int       set_len;
        int       pick;
        int       random_sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < DRILL_ROWS; row++) begin
            for (k = 0; k < drill_plan[row].reps; k++) begin
                item.sample    = drill_plan[row].sample;
                item.final_req = drill_plan[row].final_req && (k == drill_plan[row].reps - 1);
                push_sample(item);
            end
            if (drill_plan[row].pinned) begin
                // Single-item set: its one result is written down by hand.
                void'(awaited_ranks.pop_back());
                awaited_ranks = {awaited_ranks, drill_plan[row].pin};
            end
        end
        drain_results();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                set_len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                set_len = $urandom_range(9, 40);
            end else begin
                set_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            end
            if (set_len > RANDOM_ITEMS - random_sent) begin
                set_len = RANDOM_ITEMS - random_sent;
            end
            steady = ($urandom_range(0, 5) == 0);
            for (k = 0; k < set_len; k++) begin
                item.sample    = draw_sample();
                item.final_req = (k == set_len - 1);
                push_sample(item);
            end
            random_sent += set_len;
            steady = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("sent %0d samples in %0d sets (%0d with dropped samples), checked %0d results",
                 samples_sent, sets_closed, overflow_sets, results_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/argsort_pkg.sv
hdl/argsort_ctrl.sv
hdl/argsort_dp.sv
hdl/argsort_descending.sv
tb/testbench.sv
